/* design/sca_pkg.sv */
package sca_pkg;

	localparam int HANDLE_W = 9;
	localparam int LIMIT_W = 4;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 4'd8;
	localparam int TDATA_W = 16;

	typedef enum logic {
		OP_ALLOC   = 1'b0,
		OP_RELEASE = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		ST_GRANTED    = 3'd0,
		ST_RELEASED   = 3'd1,
		ST_OUT        = 3'd2,
		ST_NOT_FOUND  = 3'd3,
		ST_STACK_FULL = 3'd4
	} status_t;

	// Outcome of one transaction as decided from the pointer registers.
	// When use_mem is set, the chunk index comes from the free stack read
	// and is added to handle, which then holds the slab base.
	typedef struct packed {
		status_t               status;
		logic                  use_mem;
		logic [HANDLE_W-1:0]   handle;
	} dec_t;

endpackage

/* design/sca_stack_mem.sv */
module sca_stack_mem #(
	parameter int DEPTH = 512,
	parameter int DATA_W = 6,
	parameter int ADDR_W = 9
) (
	input  logic              clk,
	input  logic              we,
	input  logic              re,
	input  logic [ADDR_W-1:0] addr,
	input  logic [DATA_W-1:0] wdata,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* design/sca_ptrs.sv */
module sca_ptrs #(
	parameter int SLAB_CHUNKS = 64,
	parameter int MAX_SLABS = 8,
	parameter int IDX_W = $clog2(SLAB_CHUNKS),
	parameter int ADDR_W = $clog2(SLAB_CHUNKS * MAX_SLABS)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          accept,
	input  sca_pkg::op_t                  op,
	input  logic [sca_pkg::HANDLE_W-1:0]  handle_in,
	input  logic [sca_pkg::LIMIT_W-1:0]   slab_limit,
	output sca_pkg::dec_t                 dec,
	output logic                          mem_we,
	output logic                          mem_re,
	output logic [ADDR_W-1:0]             mem_addr,
	output logic [IDX_W-1:0]              mem_wdata
);

	localparam int CNT_W = $clog2(SLAB_CHUNKS + 1);
	localparam int SLAB_W = (MAX_SLABS > 1) ? $clog2(MAX_SLABS) : 1;
	localparam int OPEN_W = $clog2(MAX_SLABS + 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(SLAB_CHUNKS);
	localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

	// Per slab: chunks handed out by the bump pointer, and free stack depth.
	logic [CNT_W-1:0]  used_q [MAX_SLABS];
	logic [CNT_W-1:0]  depth_q [MAX_SLABS];
	logic [OPEN_W-1:0] open_q;

	logic              pick_found;
	logic [SLAB_W-1:0] pick_slab;
	int                rel_slab_n;
	logic [SLAB_W-1:0] rel_slab;
	logic [IDX_W-1:0]  rel_idx;

	logic              used_we;
	logic              depth_we;
	logic              open_inc;
	logic [SLAB_W-1:0] upd_slab;
	logic [CNT_W-1:0]  used_d;
	logic [CNT_W-1:0]  depth_d;

	// First open slab with a freed chunk or bump room.
	always_comb begin
		pick_found = 1'b0;
		pick_slab = '0;
		for (int s = MAX_SLABS - 1; s >= 0; s--) begin
			if (s < int'(open_q) && (depth_q[s] != '0 || used_q[s] != CNT_FULL)) begin
				pick_found = 1'b1;
				pick_slab = SLAB_W'(s);
			end
		end
	end

	// Slab of a released handle by comparison against the slab bases.
	always_comb begin
		rel_slab_n = 0;
		for (int k = 1; k <= MAX_SLABS; k++) begin
			if (int'(handle_in) >= k * SLAB_CHUNKS) begin
				rel_slab_n = rel_slab_n + 1;
			end
		end
		rel_slab = SLAB_W'(rel_slab_n);
		rel_idx = IDX_W'(int'(handle_in) - rel_slab_n * SLAB_CHUNKS);
	end

	always_comb begin
		dec.status = sca_pkg::ST_OUT;
		dec.use_mem = 1'b0;
		dec.handle = '0;
		mem_we = 1'b0;
		mem_re = 1'b0;
		mem_addr = '0;
		mem_wdata = rel_idx;
		used_we = 1'b0;
		depth_we = 1'b0;
		open_inc = 1'b0;
		upd_slab = pick_slab;
		used_d = '0;
		depth_d = '0;
		unique case (op)
			sca_pkg::OP_ALLOC: begin
				if (pick_found) begin
					dec.status = sca_pkg::ST_GRANTED;
					if (depth_q[pick_slab] != '0) begin
						// Pop: the index arrives from the free stack next cycle.
						dec.use_mem = 1'b1;
						dec.handle = sca_pkg::HANDLE_W'(int'(pick_slab) * SLAB_CHUNKS);
						mem_re = accept;
						mem_addr = ADDR_W'(int'(pick_slab) * SLAB_CHUNKS
							+ int'(depth_q[pick_slab]) - 1);
						depth_we = 1'b1;
						depth_d = depth_q[pick_slab] - CNT_ONE;
					end else begin
						dec.handle = sca_pkg::HANDLE_W'(int'(pick_slab) * SLAB_CHUNKS
							+ int'(used_q[pick_slab]));
						used_we = 1'b1;
						used_d = used_q[pick_slab] + CNT_ONE;
					end
				end else if (int'(open_q) < int'(slab_limit) && int'(open_q) < MAX_SLABS) begin
					dec.status = sca_pkg::ST_GRANTED;
					dec.handle = sca_pkg::HANDLE_W'(int'(open_q) * SLAB_CHUNKS);
					upd_slab = SLAB_W'(open_q);
					used_we = 1'b1;
					used_d = CNT_ONE;
					depth_we = 1'b1;
					depth_d = '0;
					open_inc = 1'b1;
				end
			end
			sca_pkg::OP_RELEASE: begin
				dec.handle = handle_in;
				upd_slab = rel_slab;
				if (rel_slab_n >= int'(open_q)) begin
					dec.status = sca_pkg::ST_NOT_FOUND;
				end else if (depth_q[rel_slab] == CNT_FULL) begin
					dec.status = sca_pkg::ST_STACK_FULL;
				end else begin
					dec.status = sca_pkg::ST_RELEASED;
					mem_we = accept;
					mem_addr = ADDR_W'(rel_slab_n * SLAB_CHUNKS + int'(depth_q[rel_slab]));
					depth_we = 1'b1;
					depth_d = depth_q[rel_slab] + CNT_ONE;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < MAX_SLABS; s++) begin
				used_q[s] <= '0;
				depth_q[s] <= '0;
			end
			open_q <= OPEN_W'(1);
		end else if (accept) begin
			if (used_we) begin
				used_q[upd_slab] <= used_d;
			end
			if (depth_we) begin
				depth_q[upd_slab] <= depth_d;
			end
			if (open_inc) begin
				open_q <= open_q + OPEN_W'(1);
			end
		end
	end

endmodule

/* design/slab_chunk_allocator.sv */
// A result passes the result stage (valid_s1, dec_s1) and then the output register
// before it is offered; a stall on the output side holds it in the result stage.
// Throughput: one transaction per cycle while the result side keeps up; the free
// stack memory read is registered in its port alongside the result stage.
// Reset (arst_n, asynchronous): slab 0 open, all bump pointers and free stacks
// empty, slab_limit 8; the free stack memory itself is not cleared.
module slab_chunk_allocator #(
	parameter int SLAB_CHUNKS = 64,
	parameter int MAX_SLABS = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [sca_pkg::LIMIT_W-1:0]   cfg_wdata,     // slab_limit
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [sca_pkg::TDATA_W-1:0]   s_axis_tdata,  // [8:0] handle_in
	input  logic                          s_axis_tuser,  // [0] operation
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [sca_pkg::TDATA_W-1:0]   m_axis_tdata,  // [8:0] handle_out
	output logic [2:0]                    m_axis_tuser   // [2:0] status
);

	localparam int IDX_W = $clog2(SLAB_CHUNKS);
	localparam int ADDR_W = $clog2(SLAB_CHUNKS * MAX_SLABS);

	logic [sca_pkg::LIMIT_W-1:0]  slab_limit_q;
	logic                         accept;
	logic                         out_free;
	logic                         drain;
	sca_pkg::dec_t                dec;
	sca_pkg::dec_t                dec_s1;
	logic                         valid_s1;
	logic                         mem_we;
	logic                         mem_re;
	logic [ADDR_W-1:0]            mem_addr;
	logic [IDX_W-1:0]             mem_wdata;
	logic [IDX_W-1:0]             mem_rdata;
	logic [sca_pkg::HANDLE_W-1:0] handle_res;
	logic                         out_valid_q;
	sca_pkg::status_t             out_status_q;
	logic [sca_pkg::HANDLE_W-1:0] out_handle_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slab_limit_q <= sca_pkg::LIMIT_RESET;
		end else if (cfg_we) begin
			slab_limit_q <= cfg_wdata;
		end
	end

	assign out_free = !out_valid_q || m_axis_tready;
	assign drain = valid_s1 && out_free;
	assign s_axis_tready = !valid_s1 || out_free;
	assign accept = s_axis_tvalid && s_axis_tready;

	sca_ptrs #(
		.SLAB_CHUNKS(SLAB_CHUNKS),
		.MAX_SLABS(MAX_SLABS),
		.IDX_W(IDX_W),
		.ADDR_W(ADDR_W)
	) u_ptrs (
		.clk(clk),
		.arst_n(arst_n),
		.accept(accept),
		.op(sca_pkg::op_t'(s_axis_tuser)),
		.handle_in(s_axis_tdata[sca_pkg::HANDLE_W-1:0]),
		.slab_limit(slab_limit_q),
		.dec(dec),
		.mem_we(mem_we),
		.mem_re(mem_re),
		.mem_addr(mem_addr),
		.mem_wdata(mem_wdata)
	);

	sca_stack_mem #(
		.DEPTH(SLAB_CHUNKS * MAX_SLABS),
		.DATA_W(IDX_W),
		.ADDR_W(ADDR_W)
	) u_stack_mem (
		.clk(clk),
		.we(mem_we),
		.re(mem_re),
		.addr(mem_addr),
		.wdata(mem_wdata),
		.rdata(mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (drain) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			dec_s1 <= dec;
		end
	end

	// The read data holds while the stage waits, since reads issue only on accept.
	assign handle_res = dec_s1.use_mem
		? sca_pkg::HANDLE_W'(int'(dec_s1.handle) + int'(mem_rdata))
		: dec_s1.handle;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (drain) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (drain) begin
			out_status_q <= dec_s1.status;
			out_handle_q <= handle_res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser = out_status_q;
	assign m_axis_tdata = {{(sca_pkg::TDATA_W - sca_pkg::HANDLE_W){1'b0}}, out_handle_q};

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> valid_s1)
		else $error("accepted transaction did not reach the result stage");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !out_free |=> valid_s1)
		else $error("result stage dropped a transaction while stalled");

	a_mem_one_access: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_we && mem_re))
		else $error("free stack read and write in the same cycle");

	a_mem_only_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_we || mem_re) |-> accept)
		else $error("free stack accessed without a transaction");

	a_pop_is_grant: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && dec_s1.use_mem |-> dec_s1.status == sca_pkg::ST_GRANTED)
		else $error("stack read used for a result that is not a grant");

endmodule
